// ===== rtl/core/keyed_reading_table_assert.svh =====
// assertion macros shared by the keyed reading table rtl
// each check is sampled on i_clk and held off while i_rst_n is low
`ifndef KEYED_READING_TABLE_ASSERT_SVH
`define KEYED_READING_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define KRT_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("keyed reading table check failed");

// condition implies consequence in the next cycle
`define KRT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("keyed reading table check failed");

`else

`define KRT_ASSERT_SAME(label, cond, cons)
`define KRT_ASSERT_NEXT(label, cond, cons)

`endif

`endif

// ===== rtl/core/krt_pkg.sv =====
`default_nettype none

package krt_pkg;

    // action codes of a request
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // single precision exponent field
    localparam int unsigned EXP_MSB = 30;
    localparam int unsigned EXP_LSB = 23;

    // response status codes
    typedef enum logic [2:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_DROPPED  = 3'd2,
        STAT_REJECTED = 3'd3,
        STAT_HIT      = 3'd4,
        STAT_MISS     = 3'd5,
        STAT_CLEARED  = 3'd6
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

    // one stored table entry
    typedef struct packed {
        logic [31:0] sensor;
        logic [31:0] metric;
        logic [31:0] value;
        logic [31:0] stamp;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/krt_in_if.sv =====
`default_nettype none

// request channel
interface krt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] sensor_key;
    logic [31:0] metric_key;
    logic [31:0] value_bits;
    logic [31:0] now_ms;

    modport source (
        output valid, action, sensor_key, metric_key, value_bits, now_ms,
        input  ready
    );

    modport sink (
        input  valid, action, sensor_key, metric_key, value_bits, now_ms,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/krt_out_if.sv =====
`default_nettype none

// response channel
interface krt_out_if;
    logic              valid;
    logic              ready;
    krt_pkg::t_status  status;
    logic [31:0]       value_out;
    logic [31:0]       age_ms;

    modport source (
        output valid, status, value_out, age_ms,
        input  ready
    );

    modport sink (
        input  valid, status, value_out, age_ms,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/krt_ram.sv =====
`default_nettype none

module krt_ram #(
    parameter  int WIDTH = 128,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/keyed_reading_table.sv =====
// keyed reading table: latest reading per (sensor, metric) key pair
// request channel i_req carries action, sensor_key, metric_key, value_bits
// and now_ms; response channel o_rsp carries status, value_out and age_ms.
// every request gives exactly one response, in request order.
// put and get scan the table one entry per cycle through a single compare
// unit on the entry ram read port; a key match ends the scan early.
// clear, rejected puts, unused actions and gets with an empty key skip
// the scan and go straight from acceptance to the response state.
// the block takes one request at a time: i_req.ready is high only when the
// sequencer is idle.
// a finished response sits in an output register; the next request is
// accepted while it waits, and its result is held in the sequencer until
// o_rsp.ready drains the register, so nothing is lost under stall.
// reset clears all entry valid bits and the control state; the entry ram
// itself is not cleared and only valid entries can ever match a key.
`default_nettype none

`include "keyed_reading_table_assert.svh"

module keyed_reading_table #(
    parameter  int TABLE_DEPTH = 16,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    krt_in_if.sink     i_req,
    krt_out_if.source  o_rsp
);

    localparam int          ENTRY_W  = $bits(krt_pkg::t_entry);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // control state
    krt_pkg::t_state          r_state, n_state;
    logic [CW-1:0]            r_idx, n_idx;
    logic                     r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]            r_cmp_idx, n_cmp_idx;
    logic                     r_free_found, n_free_found;
    logic [AW-1:0]            r_free_idx, n_free_idx;
    logic [TABLE_DEPTH-1:0]   r_valid, n_valid;
    logic                     r_out_valid, n_out_valid;

    // request payload
    logic [1:0]               r_action, n_action;
    logic [31:0]              r_sensor, n_sensor;
    logic [31:0]              r_metric, n_metric;
    logic [31:0]              r_value, n_value;
    logic [31:0]              r_now, n_now;

    // pending result and output register
    krt_pkg::t_status         r_res_status, n_res_status;
    logic [31:0]              r_res_value, n_res_value;
    logic [31:0]              r_res_age, n_res_age;
    krt_pkg::t_status         r_out_status, n_out_status;
    logic [31:0]              r_out_value, n_out_value;
    logic [31:0]              r_out_age, n_out_age;

    // entry ram ports
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic                     ram_re;
    logic [ENTRY_W-1:0]       ram_rdata;
    krt_pkg::t_entry          rd_entry;
    krt_pkg::t_entry          wr_entry;

    // scan compare and insert flags
    logic                     key_match;
    logic                     slot_free;
    logic                     do_insert;

    // check terms
    logic                     clear_accept;
    logic                     out_zero;

    krt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = krt_pkg::t_entry'(ram_rdata);
    assign wr_entry  = '{sensor: r_sensor, metric: r_metric, value: r_value, stamp: r_now};
    assign ram_wdata = ENTRY_W'(wr_entry);

    // shared compare unit on the entry read last cycle
    assign key_match = r_valid[r_cmp_idx] && (rd_entry.sensor == r_sensor)
                       && (rd_entry.metric == r_metric);
    assign slot_free = !r_valid[r_cmp_idx];

    // handshake outputs
    assign i_req.ready     = (r_state == krt_pkg::ST_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.value_out = r_out_value;
    assign o_rsp.age_ms    = r_out_age;

    // sequencer next state and datapath
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid;
        n_action     = r_action;
        n_sensor     = r_sensor;
        n_metric     = r_metric;
        n_value      = r_value;
        n_now        = r_now;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_age    = r_res_age;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_age    = r_out_age;
        ram_we       = 1'b0;
        ram_waddr    = r_cmp_idx;
        ram_re       = 1'b0;
        do_insert    = 1'b0;

        // output register drains on a completed transaction
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            krt_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_action     = i_req.action;
                    n_sensor     = i_req.sensor_key;
                    n_metric     = i_req.metric_key;
                    n_value      = i_req.value_bits;
                    n_now        = i_req.now_ms;
                    n_res_value  = '0;
                    n_res_age    = '0;
                    n_idx        = '0;
                    n_cmp_vld    = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = krt_pkg::ST_RESP;
                    case (i_req.action)
                        krt_pkg::ACT_PUT: begin
                            if ((&i_req.value_bits[krt_pkg::EXP_MSB:krt_pkg::EXP_LSB])
                                || (i_req.sensor_key == '0) || (i_req.metric_key == '0)) begin
                                n_res_status = krt_pkg::STAT_REJECTED;
                            end else begin
                                n_state = krt_pkg::ST_SCAN;
                            end
                        end
                        krt_pkg::ACT_GET: begin
                            if ((i_req.sensor_key == '0) || (i_req.metric_key == '0)) begin
                                n_res_status = krt_pkg::STAT_MISS;
                            end else begin
                                n_state = krt_pkg::ST_SCAN;
                            end
                        end
                        krt_pkg::ACT_CLEAR: begin
                            n_valid      = '0;
                            n_res_status = krt_pkg::STAT_CLEARED;
                        end
                        default: begin
                            n_res_status = krt_pkg::STAT_REJECTED;
                        end
                    endcase
                end
            end

            krt_pkg::ST_SCAN: begin
                // issue the next entry read
                if (r_idx < CW'(TABLE_DEPTH)) begin
                    ram_re    = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[AW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end

                // check the entry read last cycle
                if (r_cmp_vld) begin
                    if (key_match) begin
                        n_state   = krt_pkg::ST_RESP;
                        n_cmp_vld = 1'b0;
                        if (r_action == krt_pkg::ACT_PUT) begin
                            ram_we       = 1'b1;
                            n_res_status = krt_pkg::STAT_UPDATED;
                        end else begin
                            n_res_status = krt_pkg::STAT_HIT;
                            n_res_value  = rd_entry.value;
                            n_res_age    = r_now - rd_entry.stamp;
                        end
                    end else begin
                        if (slot_free && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST_IDX) begin
                            n_state   = krt_pkg::ST_RESP;
                            n_cmp_vld = 1'b0;
                            if (r_action == krt_pkg::ACT_PUT) begin
                                if (r_free_found || slot_free) begin
                                    do_insert    = 1'b1;
                                    ram_we       = 1'b1;
                                    ram_waddr    = r_free_found ? r_free_idx : r_cmp_idx;
                                    n_valid[ram_waddr] = 1'b1;
                                    n_res_status = krt_pkg::STAT_INSERTED;
                                end else begin
                                    n_res_status = krt_pkg::STAT_DROPPED;
                                end
                            end else begin
                                n_res_status = krt_pkg::STAT_MISS;
                            end
                        end
                    end
                end
            end

            krt_pkg::ST_RESP: begin
                // load the output register once it is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_age    = r_res_age;
                    n_state      = krt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = krt_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= krt_pkg::ST_IDLE;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_free_found <= n_free_found;
            r_valid      <= n_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx    <= n_cmp_idx;
        r_free_idx   <= n_free_idx;
        r_action     <= n_action;
        r_sensor     <= n_sensor;
        r_metric     <= n_metric;
        r_value      <= n_value;
        r_now        <= n_now;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_age    <= n_res_age;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_age    <= n_out_age;
    end

    // terms used by the checks below
    assign clear_accept = i_req.valid && i_req.ready && (i_req.action == krt_pkg::ACT_CLEAR);
    assign out_zero     = (r_out_value == '0) && (r_out_age == '0);

    // a clear transaction empties the table
    `KRT_ASSERT_NEXT(a_clear_empties, clear_accept, r_valid == '0)

    // an insert claims exactly one new slot
    `KRT_ASSERT_NEXT(a_insert_one, do_insert, $countones(r_valid) == $past($countones(r_valid)) + 1)

    // only a hit carries value and age
    `KRT_ASSERT_SAME(a_nonhit_zero, r_out_valid && (r_out_status != krt_pkg::STAT_HIT), out_zero)

    // the ram is written only while scanning
    `KRT_ASSERT_SAME(a_write_in_scan, ram_we, r_state == krt_pkg::ST_SCAN)

endmodule

`default_nettype wire
